>>> rtl/lfba_pkg.sv
// Shared constants, codes and types of the LED fade and breath animator.
package lfba_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int NUM_W = 24;
  localparam int DEN_W = 16;
  localparam int DIV_CW = $clog2(NUM_W);

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [15:0] PERIOD_DEF = 16'd200;
  localparam logic [15:0] PERIOD_MIN = 16'd2;
  localparam logic [7:0] SOLID_STEP_DEF = 8'd4;
  localparam logic [7:0] BREATH_STEP_DEF = 8'd2;

  // Command codes.
  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_SET = 3'd1;
  localparam logic [2:0] ACT_SOLID = 3'd2;
  localparam logic [2:0] ACT_BREATH = 3'd3;
  localparam logic [2:0] ACT_FADE_IN = 3'd4;
  localparam logic [2:0] ACT_FADE_OUT = 3'd5;

  // Channel mode codes.
  localparam logic [2:0] MODE_OFF = 3'd0;
  localparam logic [2:0] MODE_SOLID = 3'd1;
  localparam logic [2:0] MODE_FADE_IN = 3'd2;
  localparam logic [2:0] MODE_FADE_OUT = 3'd3;
  localparam logic [2:0] MODE_BREATH = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_SOLID_GOAL = 3'd0;
  localparam logic [2:0] REG_SOLID_STEP = 3'd1;
  localparam logic [2:0] REG_BREATH_MIN = 3'd2;
  localparam logic [2:0] REG_BREATH_MAX = 3'd3;
  localparam logic [2:0] REG_BREATH_PERIOD = 3'd4;
  localparam logic [2:0] REG_BREATH_STEP = 3'd5;

  // One channel's stored state.
  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  bright;
    logic [6:0]  target;
    logic [7:0]  step;
    logic [6:0]  low;
    logic [6:0]  high;
    logic [15:0] period;
    logic [15:0] phase;
  } chan_t;

  // Clamp an 8-bit level to a percent.
  function automatic logic [6:0] clamp8(input logic [7:0] v);
    clamp8 = (v > 8'(PCT_MAX)) ? PCT_MAX : v[6:0];
  endfunction

endpackage

>>> rtl/lfba_if.sv
// Channel interfaces of the LED fade and breath animator.
interface lfba_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] channel;
  logic [7:0] level;
  logic       interpolate;
  modport source (output valid, action, channel, level, interpolate, input ready);
  modport sink (input valid, action, channel, level, interpolate, output ready);
endinterface

interface lfba_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_channel;
  logic [6:0] brightness;
  logic       last;
  modport source (output valid, out_channel, brightness, last, input ready);
  modport sink (input valid, out_channel, brightness, last, output ready);
endinterface

interface lfba_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/led_fade_breath_animator.sv
// Top level of the LED fade and breath animator.
//
// Channels: cmd takes one command beat (action, channel, level, interpolate),
// res gives result beats (out_channel, brightness, last), cfg writes one of
// six registers (index, data) and is always ready.
// A tick command steps every channel and gives one beat per channel, channel
// 0 first, last set on the final one. Any other command gives one beat with
// last set, reporting the addressed channel after the command; a channel id
// at or above the channel count changes nothing and reports 0.
// Per-channel state lives in a small synchronous memory; each channel is
// read, updated and written back in turn. A command with an out-of-range
// channel id skips the read and goes straight to its beat. Each breathing
// channel in a tick makes two passes through the serial divider (phase
// modulo period, then level scaling); off, solid and fade modes skip it.
// cmd is ready only while no command is in progress. The result sits in an
// output register; a stalled receiver holds the sequencer before it writes
// the next channel back. Reset clears all channel state to off at once and
// loads the register defaults; no clearing pass is needed.
module led_fade_breath_animator (
  input  logic              clk,
  input  logic              rst,
  lfba_cmd_if.sink          cmd,
  lfba_res_if.source        res,
  lfba_cfg_if.sink          cfg
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CALC, S_MOD, S_LVL, S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0]  solid_goal, solid_step, breath_min, breath_max, breath_step;
  logic [15:0] breath_period;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      solid_goal <= 8'd100;
      solid_step <= 8'd4;
      breath_min <= 8'd10;
      breath_max <= 8'd100;
      breath_period <= 16'd200;
      breath_step <= 8'd2;
    end else if (cfg.valid) begin
      case (cfg.index)
        lfba_pkg::REG_SOLID_GOAL: solid_goal <= cfg.data[7:0];
        lfba_pkg::REG_SOLID_STEP: solid_step <= cfg.data[7:0];
        lfba_pkg::REG_BREATH_MIN: breath_min <= cfg.data[7:0];
        lfba_pkg::REG_BREATH_MAX: breath_max <= cfg.data[7:0];
        lfba_pkg::REG_BREATH_PERIOD: breath_period <= cfg.data;
        lfba_pkg::REG_BREATH_STEP: breath_step <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Channel state memory with valid bits; an unwritten entry reads as zero.
  lfba_pkg::chan_t             mem [lfba_pkg::CHANNELS];
  logic [lfba_pkg::CHANNELS-1:0] mem_vld;
  lfba_pkg::chan_t             rd_data;
  logic                        rd_vld;
  logic                        mem_we;
  lfba_pkg::chan_t             cur;

  // Command registers.
  logic [2:0]              act;
  logic [3:0]              ch_id;
  logic [lfba_pkg::CH_W-1:0] idx;
  logic [7:0]              lvl_in;
  logic                    interp;
  logic                    in_range;
  logic                    in_range_q;
  logic                    emit_last;

  lfba_pkg::chan_t         ent;
  logic [15:0]             half;
  logic [6:0]              span;
  logic                    lower;

  // Divider.
  logic                         div_start;
  logic                         div_done;
  logic [lfba_pkg::NUM_W-1:0]   div_num;
  logic [lfba_pkg::DEN_W-1:0]   div_den;
  logic [lfba_pkg::NUM_W-1:0]   div_q;
  logic [lfba_pkg::DEN_W-1:0]   div_r;

  lfba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
    if (mem_we) begin
      mem[idx] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= mem_vld[idx];
      if (mem_we) begin
        mem_vld[idx] <= 1'b1;
      end
    end
  end

  assign cur = rd_vld ? rd_data : '0;

  // Command update of the addressed channel.
  lfba_pkg::chan_t cmd_ent;
  logic [15:0]     per_cfg;

  always_comb begin
    cmd_ent = cur;
    per_cfg = (breath_period == 16'd0) ? lfba_pkg::PERIOD_DEF : breath_period;
    if (per_cfg == 16'd1) begin
      per_cfg = lfba_pkg::PERIOD_MIN;
    end
    case (act)
      lfba_pkg::ACT_SET: begin
        cmd_ent.mode = lfba_pkg::MODE_SOLID;
        cmd_ent.target = lfba_pkg::clamp8(lvl_in);
        cmd_ent.bright = lfba_pkg::clamp8(lvl_in);
      end
      lfba_pkg::ACT_SOLID: begin
        cmd_ent.mode = lfba_pkg::MODE_SOLID;
        cmd_ent.target = lfba_pkg::clamp8(solid_goal);
        cmd_ent.step = (solid_step == 8'd0) ? lfba_pkg::SOLID_STEP_DEF : solid_step;
        if (!interp) begin
          cmd_ent.bright = lfba_pkg::clamp8(solid_goal);
        end
      end
      lfba_pkg::ACT_BREATH: begin
        cmd_ent.mode = lfba_pkg::MODE_BREATH;
        cmd_ent.low = lfba_pkg::clamp8(breath_min);
        cmd_ent.high = lfba_pkg::clamp8(breath_max);
        cmd_ent.period = per_cfg;
        cmd_ent.step = (breath_step == 8'd0) ? lfba_pkg::BREATH_STEP_DEF : breath_step;
        if (!interp) begin
          cmd_ent.phase = 16'd0;
        end
      end
      lfba_pkg::ACT_FADE_IN: begin
        cmd_ent.mode = lfba_pkg::MODE_FADE_IN;
        cmd_ent.target = lfba_pkg::PCT_MAX;
        if (cur.step == 8'd0) begin
          cmd_ent.step = lfba_pkg::SOLID_STEP_DEF;
        end
      end
      lfba_pkg::ACT_FADE_OUT: begin
        cmd_ent.mode = lfba_pkg::MODE_FADE_OUT;
        cmd_ent.target = 7'd0;
        if (cur.step == 8'd0) begin
          cmd_ent.step = lfba_pkg::SOLID_STEP_DEF;
        end
      end
      default: ;
    endcase
  end

  // Tick update for the ramping modes.
  lfba_pkg::chan_t tick_ent;
  logic [8:0]      up_sum;
  logic signed [9:0] dn_sum;
  logic [15:0]     per_ch;

  always_comb begin
    tick_ent = cur;
    up_sum = {2'b0, cur.bright} + {1'b0, cur.step};
    dn_sum = $signed({3'b0, cur.bright}) - $signed({2'b0, cur.step});
    per_ch = (cur.period == 16'd0) ? lfba_pkg::PERIOD_DEF : cur.period;
    if (per_ch == 16'd1) begin
      per_ch = lfba_pkg::PERIOD_MIN;
    end
    case (cur.mode)
      lfba_pkg::MODE_OFF: tick_ent.bright = 7'd0;
      lfba_pkg::MODE_SOLID: begin
        if (cur.bright < cur.target) begin
          tick_ent.bright = (up_sum > {2'b0, cur.target}) ? cur.target : up_sum[6:0];
        end else if (cur.bright > cur.target) begin
          tick_ent.bright = (dn_sum < $signed({3'b0, cur.target})) ? cur.target
                                                                  : dn_sum[6:0];
        end
      end
      lfba_pkg::MODE_FADE_IN: begin
        tick_ent.mode = lfba_pkg::MODE_SOLID;
        if (cur.bright < cur.target) begin
          if (up_sum >= {2'b0, cur.target}) begin
            tick_ent.bright = cur.target;
          end else begin
            tick_ent.bright = up_sum[6:0];
            tick_ent.mode = lfba_pkg::MODE_FADE_IN;
          end
        end
      end
      lfba_pkg::MODE_FADE_OUT: begin
        tick_ent.mode = lfba_pkg::MODE_OFF;
        if (cur.bright > cur.target) begin
          if (dn_sum <= $signed({3'b0, cur.target})) begin
            tick_ent.bright = cur.target;
          end else begin
            tick_ent.bright = dn_sum[6:0];
            tick_ent.mode = lfba_pkg::MODE_FADE_OUT;
          end
        end
      end
      default: tick_ent.period = per_ch;
    endcase
  end

  // Breath level from the scaled offset.
  logic [7:0]        up_lvl;
  logic signed [8:0] dn_lvl;
  logic [6:0]        breath_lvl;

  assign up_lvl = {1'b0, ent.low} + {1'b0, div_q[6:0]};
  assign dn_lvl = $signed({2'b0, ent.high}) - $signed({2'b0, div_q[6:0]});

  always_comb begin
    if (lower) begin
      breath_lvl = (up_lvl > {1'b0, lfba_pkg::PCT_MAX}) ? lfba_pkg::PCT_MAX : up_lvl[6:0];
    end else begin
      breath_lvl = dn_lvl[8] ? 7'd0 : dn_lvl[6:0];
    end
  end

  assign in_range = ({1'b0, cmd.channel} < 5'(lfba_pkg::CHANNELS));
  assign cmd.ready = (state == S_IDLE);
  assign mem_we = (state == S_EMIT) && (!res.valid || res.ready) && in_range_q;

  assign emit_last = (act != lfba_pkg::ACT_TICK) ||
                     (idx == lfba_pkg::CH_W'(lfba_pkg::CHANNELS - 1));

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res.valid <= 1'b0;
      div_start <= 1'b0;
      idx <= '0;
    end else begin
      div_start <= 1'b0;
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act <= cmd.action;
            ch_id <= cmd.channel;
            lvl_in <= cmd.level;
            interp <= cmd.interpolate;
            if (cmd.action == lfba_pkg::ACT_TICK) begin
              idx <= '0;
              in_range_q <= 1'b1;
              state <= S_RD;
            end else begin
              idx <= cmd.channel[lfba_pkg::CH_W-1:0];
              in_range_q <= in_range;
              ent <= '0;
              state <= in_range ? S_RD : S_EMIT;
            end
          end
        end
        S_RD: state <= S_CALC;
        S_CALC: begin
          if (act != lfba_pkg::ACT_TICK) begin
            ent <= cmd_ent;
            state <= S_EMIT;
          end else begin
            ent <= tick_ent;
            if (cur.mode >= lfba_pkg::MODE_BREATH) begin
              div_num <= lfba_pkg::NUM_W'({1'b0, cur.phase} + 17'd1);
              div_den <= per_ch;
              half <= {1'b0, per_ch[15:1]};
              span <= (cur.high >= cur.low) ? cur.high - cur.low : cur.low - cur.high;
              div_start <= 1'b1;
              state <= S_MOD;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_MOD: begin
          if (div_done) begin
            ent.phase <= div_r;
            lower <= (div_r < half);
            state <= S_LVL;
            div_start <= 1'b1;
            div_num <= lfba_pkg::NUM_W'(span) *
                       lfba_pkg::NUM_W'((div_r < half) ? div_r : div_r - half);
            div_den <= half;
          end
        end
        S_LVL: begin
          if (div_done) begin
            ent.bright <= breath_lvl;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.out_channel <= (act == lfba_pkg::ACT_TICK) ? 4'(idx) : ch_id;
            res.brightness <= in_range_q ? ent.bright : 7'd0;
            res.last <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bright_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.brightness <= lfba_pkg::PCT_MAX)
    else $error("brightness above full scale");

  a_last_order: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last) |-> res.out_channel < 4'(lfba_pkg::CHANNELS - 1))
    else $error("tick beat without last on final channel");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD || state == S_LVL) |-> !cmd.ready)
    else $error("command ready while divider in use");
`endif

endmodule

>>> rtl/lfba_div.sv
// Restoring serial divider, one quotient bit per cycle.
module lfba_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lfba_pkg::NUM_W-1:0] dividend,
  input  logic [lfba_pkg::DEN_W-1:0] divisor,
  output logic                       done,
  output logic [lfba_pkg::NUM_W-1:0] quot,
  output logic [lfba_pkg::DEN_W-1:0] rem
);

  logic                        busy;
  logic [lfba_pkg::DIV_CW-1:0] cnt;
  logic [lfba_pkg::NUM_W-1:0]  dvd;
  logic [lfba_pkg::DEN_W-1:0]  den;
  logic [lfba_pkg::DEN_W-1:0]  r;
  logic [lfba_pkg::DEN_W:0]    trial;
  logic                        ge;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {r, dvd[lfba_pkg::NUM_W-1]};
  assign ge = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lfba_pkg::DIV_CW'(lfba_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient collects in the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      den <= divisor;
      r <= '0;
    end else if (busy) begin
      r <= ge ? lfba_pkg::DEN_W'(trial - {1'b0, den}) : trial[lfba_pkg::DEN_W-1:0];
      dvd <= {dvd[lfba_pkg::NUM_W-2:0], ge};
    end
  end

  assign quot = dvd;
  assign rem = r;

endmodule

>>> tb/sv/led_fade_breath_animator_tb.sv
// Self-checking testbench of the LED fade and breath animator.
`timescale 1ns / 100ps

module led_fade_breath_animator_tb;

  // Action codes with no command behind them; the block treats them as queries.
  localparam logic [2:0] ACT_QUERY_A = 3'd6;
  localparam logic [2:0] ACT_QUERY_B = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES = 400;
  localparam int SEG_ITEMS = 40;

  typedef struct {
    logic [3:0] ch;
    logic [6:0] bright;
    logic       last;
  } led_beat_t;

  typedef struct {
    logic [2:0] act;
    logic [3:0] ch;
    logic [7:0] lvl;
    logic       ip;
    bit         typed;
    logic [6:0] bright;
  } cmd_row_t;

  logic clk;
  logic rst;

  lfba_cmd_if cmd_if ();
  lfba_res_if res_if ();
  lfba_cfg_if cfg_if ();

  led_fade_breath_animator u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // Register copies and per-channel animation state.
  logic [7:0]  r_solid_goal, r_solid_step, r_breath_min, r_breath_max, r_breath_step;
  logic [15:0] r_breath_period;
  logic [2:0]  ch_mode [lfba_pkg::CHANNELS];
  logic [6:0]  ch_bright [lfba_pkg::CHANNELS];
  logic [6:0]  ch_target [lfba_pkg::CHANNELS];
  logic [7:0]  ch_step [lfba_pkg::CHANNELS];
  logic [6:0]  ch_low [lfba_pkg::CHANNELS];
  logic [6:0]  ch_high [lfba_pkg::CHANNELS];
  logic [15:0] ch_period [lfba_pkg::CHANNELS];
  logic [15:0] ch_phase [lfba_pkg::CHANNELS];

  led_beat_t pending_levels [$];
  int fails = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 50;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Directed commands; brightness is typed only where it is plain.
  cmd_row_t dir_rows [22] = '{
    '{lfba_pkg::ACT_TICK,     4'd0,  8'd0,   1'b0, 1'b0, 7'd0},
    '{lfba_pkg::ACT_SET,      4'd0,  8'd255, 1'b0, 1'b1, 7'd100},
    '{lfba_pkg::ACT_SET,      4'd1,  8'd0,   1'b1, 1'b1, 7'd0},
    '{lfba_pkg::ACT_SET,      4'd15, 8'd77,  1'b0, 1'b1, 7'd0},
    '{ACT_QUERY_A,            4'd0,  8'd0,   1'b0, 1'b1, 7'd100},
    '{ACT_QUERY_B,            4'd3,  8'd255, 1'b1, 1'b1, 7'd0},
    '{lfba_pkg::ACT_SOLID,    4'd2,  8'd0,   1'b0, 1'b1, 7'd100},
    '{lfba_pkg::ACT_SOLID,    4'd1,  8'd0,   1'b1, 1'b1, 7'd0},
    '{lfba_pkg::ACT_BREATH,   4'd3,  8'd0,   1'b0, 1'b1, 7'd0},
    '{lfba_pkg::ACT_FADE_OUT, 4'd0,  8'd0,   1'b0, 1'b1, 7'd100},
    '{lfba_pkg::ACT_FADE_IN,  4'd1,  8'd0,   1'b0, 1'b1, 7'd0},
    '{lfba_pkg::ACT_TICK,     4'd0,  8'd0,   1'b0, 1'b0, 7'd0},
    '{lfba_pkg::ACT_TICK,     4'd9,  8'd0,   1'b1, 1'b0, 7'd0},
    '{lfba_pkg::ACT_TICK,     4'd0,  8'd0,   1'b0, 1'b0, 7'd0},
    '{lfba_pkg::ACT_BREATH,   4'd2,  8'd0,   1'b1, 1'b0, 7'd0},
    '{lfba_pkg::ACT_TICK,     4'd0,  8'd0,   1'b0, 1'b0, 7'd0},
    '{lfba_pkg::ACT_SET,      4'd3,  8'd100, 1'b0, 1'b1, 7'd100},
    '{lfba_pkg::ACT_SET,      4'd2,  8'd101, 1'b0, 1'b1, 7'd100},
    '{lfba_pkg::ACT_FADE_OUT, 4'd4,  8'd0,   1'b0, 1'b1, 7'd0},
    '{lfba_pkg::ACT_FADE_IN,  4'd12, 8'd0,   1'b1, 1'b1, 7'd0},
    '{lfba_pkg::ACT_FADE_OUT, 4'd3,  8'd0,   1'b0, 1'b1, 7'd100},
    '{lfba_pkg::ACT_TICK,     4'd0,  8'd0,   1'b0, 1'b0, 7'd0}
  };

  function automatic logic [6:0] to_pct(input int v);
    if (v < 0) return 7'd0;
    if (v > 100) return 7'd100;
    return v[6:0];
  endfunction

  // Advance one channel by one animation tick.
  task automatic tick_channel(input int c);
    int b, t, s, nx, per, half, pos, span, lvl;
    b = ch_bright[c];
    t = ch_target[c];
    s = ch_step[c];
    case (ch_mode[c])
      lfba_pkg::MODE_OFF: ch_bright[c] = 7'd0;
      lfba_pkg::MODE_SOLID: begin
        if (b < t) begin
          nx = (b + s > t) ? t : b + s;
          ch_bright[c] = nx[6:0];
        end else if (b > t) begin
          nx = (b - s < t) ? t : b - s;
          ch_bright[c] = nx[6:0];
        end
      end
      lfba_pkg::MODE_FADE_IN: begin
        if (b < t) begin
          nx = b + s;
          if (nx >= t) begin
            nx = t;
            ch_mode[c] = lfba_pkg::MODE_SOLID;
          end
          ch_bright[c] = nx[6:0];
        end else begin
          ch_mode[c] = lfba_pkg::MODE_SOLID;
        end
      end
      lfba_pkg::MODE_FADE_OUT: begin
        if (b > t) begin
          nx = b - s;
          if (nx <= t) begin
            nx = t;
            ch_mode[c] = lfba_pkg::MODE_OFF;
          end
          ch_bright[c] = nx[6:0];
        end else begin
          ch_mode[c] = lfba_pkg::MODE_OFF;
        end
      end
      default: begin
        // Breathing, and any mode code past it, follows the triangle wave.
        per = ch_period[c];
        if (per == 0) per = 200;
        if (per == 1) per = 2;
        ch_period[c] = per[15:0];
        pos = (int'(ch_phase[c]) + 1) % per;
        ch_phase[c] = pos[15:0];
        half = per / 2;
        span = int'(ch_high[c]) - int'(ch_low[c]);
        if (span < 0) span = -span;
        if (pos < half) lvl = int'(ch_low[c]) + (span * pos) / half;
        else lvl = int'(ch_high[c]) - (span * (pos - half)) / half;
        ch_bright[c] = to_pct(lvl);
      end
    endcase
  endtask

  // Apply one accepted command and queue the brightness beats it yields.
  task automatic animate_step(input logic [2:0] act, input logic [3:0] ch,
                              input logic [7:0] lvl, input logic ip);
    led_beat_t beat;
    int per;
    if (act == lfba_pkg::ACT_TICK) begin
      for (int c = 0; c < lfba_pkg::CHANNELS; c++) begin
        tick_channel(c);
        beat.ch = c[3:0];
        beat.bright = ch_bright[c];
        beat.last = (c == lfba_pkg::CHANNELS - 1);
        pending_levels.push_back(beat);
      end
      return;
    end
    beat.ch = ch;
    beat.last = 1'b1;
    beat.bright = 7'd0;
    if (ch < lfba_pkg::CHANNELS) begin
      case (act)
        lfba_pkg::ACT_SET: begin
          ch_mode[ch] = lfba_pkg::MODE_SOLID;
          ch_target[ch] = to_pct(lvl);
          ch_bright[ch] = ch_target[ch];
        end
        lfba_pkg::ACT_SOLID: begin
          ch_mode[ch] = lfba_pkg::MODE_SOLID;
          ch_target[ch] = to_pct(r_solid_goal);
          ch_step[ch] = (r_solid_step != 0) ? r_solid_step : lfba_pkg::SOLID_STEP_DEF;
          if (!ip) ch_bright[ch] = ch_target[ch];
        end
        lfba_pkg::ACT_BREATH: begin
          per = (r_breath_period != 0) ? int'(r_breath_period) : 200;
          if (per == 1) per = 2;
          ch_mode[ch] = lfba_pkg::MODE_BREATH;
          ch_low[ch] = to_pct(r_breath_min);
          ch_high[ch] = to_pct(r_breath_max);
          ch_period[ch] = per[15:0];
          ch_step[ch] = (r_breath_step != 0) ? r_breath_step : lfba_pkg::BREATH_STEP_DEF;
          if (!ip) ch_phase[ch] = 16'd0;
        end
        lfba_pkg::ACT_FADE_IN: begin
          ch_mode[ch] = lfba_pkg::MODE_FADE_IN;
          ch_target[ch] = lfba_pkg::PCT_MAX;
          if (ch_step[ch] == 0) ch_step[ch] = lfba_pkg::SOLID_STEP_DEF;
        end
        lfba_pkg::ACT_FADE_OUT: begin
          ch_mode[ch] = lfba_pkg::MODE_FADE_OUT;
          ch_target[ch] = 7'd0;
          if (ch_step[ch] == 0) ch_step[ch] = lfba_pkg::SOLID_STEP_DEF;
        end
        default: ;
      endcase
      beat.bright = ch_bright[ch];
    end
    pending_levels.push_back(beat);
  endtask

  // Offer one command beat after an optional random gap, then predict it.
  task automatic send_cmd(input logic [2:0] act, input logic [3:0] ch,
                          input logic [7:0] lvl, input logic ip);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.action <= act;
    cmd_if.channel <= ch;
    cmd_if.level <= lvl;
    cmd_if.interpolate <= ip;
    do @(posedge clk); while (!cmd_if.ready);
    animate_step(act, ch, lvl, ip);
  endtask

  // Wait until every expected beat has come, then let the block go quiet.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register beat; the caller drops valid after its last write.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      lfba_pkg::REG_SOLID_GOAL:    r_solid_goal = value[7:0];
      lfba_pkg::REG_SOLID_STEP:    r_solid_step = value[7:0];
      lfba_pkg::REG_BREATH_MIN:    r_breath_min = value[7:0];
      lfba_pkg::REG_BREATH_MAX:    r_breath_max = value[7:0];
      lfba_pkg::REG_BREATH_PERIOD: r_breath_period = value;
      lfba_pkg::REG_BREATH_STEP:   r_breath_step = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [7:0] lvl, input logic [7:0] sstep,
                                input logic [7:0] bmin, input logic [7:0] bmax,
                                input logic [15:0] per, input logic [7:0] bstep);
    write_reg(lfba_pkg::REG_SOLID_GOAL, {8'd0, lvl});
    write_reg(lfba_pkg::REG_SOLID_STEP, {8'd0, sstep});
    write_reg(lfba_pkg::REG_BREATH_MIN, {8'd0, bmin});
    write_reg(lfba_pkg::REG_BREATH_MAX, {8'd0, bmax});
    write_reg(lfba_pkg::REG_BREATH_PERIOD, per);
    write_reg(lfba_pkg::REG_BREATH_STEP, {8'd0, bstep});
    cfg_if.valid <= 1'b0;
  endtask

  // Clock: 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random back-pressure, long hold-offs on request, beat checks.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_levels.size() == 0) begin
          $error("unexpected result beat: out_channel %0d brightness %0d",
                 res_if.out_channel, res_if.brightness);
          fails++;
        end else begin
          if (res_if.out_channel !== pending_levels[0].ch) begin
            $error("out_channel: expected %0d, actual %0d",
                   pending_levels[0].ch, res_if.out_channel);
            fails++;
          end
          if (res_if.brightness !== pending_levels[0].bright) begin
            $error("brightness: expected %0d, actual %0d",
                   pending_levels[0].bright, res_if.brightness);
            fails++;
          end
          if (res_if.last !== pending_levels[0].last) begin
            $error("last: expected %0d, actual %0d",
                   pending_levels[0].last, res_if.last);
            fails++;
          end
          void'(pending_levels.pop_front());
        end
      end
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any accepted beat ends the run.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed commands, then random segments per setting.
  initial begin
    logic [2:0] act;
    logic [3:0] ch;
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.action <= lfba_pkg::ACT_TICK;
    cmd_if.channel <= 4'd0;
    cmd_if.level <= 8'd0;
    cmd_if.interpolate <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= lfba_pkg::REG_SOLID_GOAL;
    cfg_if.data <= 16'd0;
    r_solid_goal = 8'd100;
    r_solid_step = lfba_pkg::SOLID_STEP_DEF;
    r_breath_min = 8'd10;
    r_breath_max = 8'd100;
    r_breath_period = lfba_pkg::PERIOD_DEF;
    r_breath_step = lfba_pkg::BREATH_STEP_DEF;
    for (int c = 0; c < lfba_pkg::CHANNELS; c++) begin
      ch_mode[c] = lfba_pkg::MODE_OFF;
      ch_bright[c] = 7'd0;
      ch_target[c] = 7'd0;
      ch_step[c] = 8'd0;
      ch_low[c] = 7'd0;
      ch_high[c] = 7'd0;
      ch_period[c] = 16'd0;
      ch_phase[c] = 16'd0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run against the reset register values.
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].act, dir_rows[i].ch, dir_rows[i].lvl, dir_rows[i].ip);
      if (dir_rows[i].typed) pending_levels[$].bright = dir_rows[i].bright;
    end

    for (int seg = 0; seg < 4; seg++) begin
      drain_results();
      case (seg)
        0: write_all_regs(8'd255, 8'd0, 8'd255, 8'd0, 16'd1, 8'd0);
        1: write_all_regs(8'd0, 8'd255, 8'd0, 8'd255, 16'd0, 8'd255);
        2: write_all_regs(8'd60, 8'd3, 8'd20, 8'd80, 16'hFFFF, 8'd7);
        default: write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 8'($urandom_range(255)),
                                16'($urandom_range(1, 40)), 8'($urandom_range(255)));
      endcase
      // Idle mix: receiver-heavy first, then sender-heavy, then none.
      if (seg == 0) begin
        send_idle_pct = 38;
        recv_idle_pct = 50;
      end else if (seg == 1) begin
        send_idle_pct = 50;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < SEG_ITEMS; i++) begin
        // The receiver stalls for a long stretch while commands keep coming.
        if ((seg == 1 || seg == 2) && i == 10) hold_asked++;
        act = ($urandom_range(99) < 40) ? lfba_pkg::ACT_TICK : 3'($urandom_range(1, 7));
        ch = ($urandom_range(99) < 80) ? 4'($urandom_range(lfba_pkg::CHANNELS - 1))
                                       : 4'($urandom_range(15));
        send_cmd(act, ch, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end

    drain_results();
    if (fails == 0 && pending_levels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
